@@ design/hbbd_pkg.sv @@
package hbbd_pkg;

  localparam int LINK_W = 6;
  localparam logic [LINK_W-1:0] NO_LINK = 6'd63;
  localparam logic [7:0] REFS_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_REL   = 2'd1,
    OP_PIN   = 2'd2,
    OP_UNPIN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef struct packed {
    op_t         opcode;
    logic [7:0]  device_number;
    logic [31:0] block_number;
    logic [4:0]  buffer_select;
  } req_t;

  typedef struct packed {
    logic [4:0] buffer_index;
    logic       hit;
    logic       needs_fill;
    status_t    status;
  } rsp_t;

endpackage

@@ design/hashed_block_buffer_directory_core.sv @@
// Buffer directory of a block cache: buffers sit in per-bucket linked lists, a block hashes to
// bucket block_number mod BUCKET_COUNT. One item is handled at a time by a small sequencer
// around a single walker that visits one list entry per cycle. A read first reduces the
// block number to its bucket (folding the bytes with constant residues, then a reciprocal
// multiply), then walks its bucket for a match and again for an unreferenced buffer; on a
// full miss it walks the other buckets in order and relinks the victim. A finished result
// waits in an output register.
module hashed_block_buffer_directory_core #(
  parameter int BUFFER_COUNT = 32,
  parameter int BUCKET_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  hbbd_pkg::req_t      req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output hbbd_pkg::rsp_t      rsp
);

  localparam int IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int SW = $clog2(BUFFER_COUNT + 1);
  localparam int LW = hbbd_pkg::LINK_W;
  // residues of the byte weights, and the reciprocal for the folded value
  localparam int C1 = 256 % BUCKET_COUNT;
  localparam int C2 = 65536 % BUCKET_COUNT;
  localparam int C3 = (1 << 24) % BUCKET_COUNT;
  localparam int RS = 15 + BW;
  localparam longint unsigned RECIP =
    ((64'd1 << RS) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_MATCH, S_FREE, S_STEAL_HEAD, S_STEAL_WALK,
    S_UNLINK, S_INSERT, S_OP, S_FINISH
  } state_t;

  state_t state;

  logic [7:0]    entry_device [BUFFER_COUNT];
  logic [31:0]   entry_block  [BUFFER_COUNT];
  logic          entry_valid  [BUFFER_COUNT];
  logic [7:0]    entry_refs   [BUFFER_COUNT];
  logic [LW-1:0] entry_link   [BUFFER_COUNT];
  logic [LW-1:0] bucket_first [BUCKET_COUNT];

  hbbd_pkg::op_t op;
  logic [7:0]    dev;
  logic [31:0]   blk;
  logic [1:0]    hash_cnt;
  logic [14:0]   fold;
  logic [14:0]   quot;
  logic [BW-1:0] bk;
  logic [BW:0]   ob;
  logic [LW-1:0] cur;
  logic [SW-1:0] steps;
  logic [LW-1:0] victim;
  logic [LW-1:0] vlink;
  logic [LW-1:0] grant;
  logic          hit;
  logic          fill;
  hbbd_pkg::status_t status;

  logic [14:0]   fold_calc;
  logic [31:0]   recip_prod;
  logic [14:0]   rem_calc;
  logic [IW-1:0] ci;
  logic          cur_ok;
  logic          walk_end;
  logic [BW-1:0] bsel;
  logic [LW-1:0] first_rd;
  logic [7:0]    rd_refs;
  logic [LW-1:0] rd_link;
  logic          is_match;
  logic [7:0]    refs_inc;

  // block number mod bucket count, one stage per cycle
  assign fold_calc  = 15'(blk[7:0]) + 15'(blk[15:8]) * 15'(C1)
                    + 15'(blk[23:16]) * 15'(C2) + 15'(blk[31:24]) * 15'(C3);
  assign recip_prod = 32'(fold) * 32'(RECIP);
  assign rem_calc   = fold - quot * 15'(BUCKET_COUNT);

  assign ci       = cur[IW-1:0];
  assign cur_ok   = cur < LW'(BUFFER_COUNT);
  assign walk_end = !cur_ok || (steps == SW'(BUFFER_COUNT));
  assign bsel     = (state == S_STEAL_HEAD || state == S_STEAL_WALK) ? ob[BW-1:0] : bk;
  assign first_rd = bucket_first[bsel];
  assign rd_refs  = entry_refs[ci];
  assign rd_link  = entry_link[ci];
  assign is_match = (entry_device[ci] == dev) && (entry_block[ci] == blk);
  assign refs_inc = (rd_refs != hbbd_pkg::REFS_MAX) ? rd_refs + 8'd1 : rd_refs;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int b = 0; b < BUCKET_COUNT; b++) begin
        if (b < BUFFER_COUNT) begin
          bucket_first[b] <= LW'(b + BUCKET_COUNT * ((BUFFER_COUNT - 1 - b) / BUCKET_COUNT));
        end else begin
          bucket_first[b] <= hbbd_pkg::NO_LINK;
        end
      end
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        entry_device[i] <= '0;
        entry_block[i]  <= '0;
        entry_valid[i]  <= 1'b0;
        entry_refs[i]   <= '0;
        entry_link[i]   <= (i >= BUCKET_COUNT) ? LW'(i - BUCKET_COUNT) : hbbd_pkg::NO_LINK;
      end
    end else begin
      if (rsp_valid && rsp_ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op       <= req.opcode;
            dev      <= req.device_number;
            blk      <= req.block_number;
            hash_cnt <= '0;
            hit      <= 1'b0;
            fill     <= 1'b0;
            status   <= hbbd_pkg::ST_OK;
            grant    <= {1'b0, req.buffer_select};
            cur      <= {1'b0, req.buffer_select};
            state    <= (req.opcode == hbbd_pkg::OP_READ) ? S_HASH : S_OP;
          end
        end
        S_HASH: begin
          hash_cnt <= hash_cnt + 2'd1;
          case (hash_cnt)
            2'd0: fold <= fold_calc;
            2'd1: quot <= 15'(recip_prod >> RS);
            2'd2: bk   <= rem_calc[BW-1:0];
            default: begin
              cur   <= first_rd;
              steps <= '0;
              state <= S_MATCH;
            end
          endcase
        end
        S_MATCH: begin
          if (walk_end) begin
            cur   <= first_rd;
            steps <= '0;
            state <= S_FREE;
          end else if (is_match) begin
            grant            <= cur;
            hit              <= 1'b1;
            fill             <= !entry_valid[ci];
            entry_valid[ci]  <= 1'b1;
            entry_refs[ci]   <= refs_inc;
            state            <= S_FINISH;
          end else begin
            cur   <= rd_link;
            steps <= steps + SW'(1);
          end
        end
        S_FREE: begin
          if (walk_end) begin
            ob    <= '0;
            state <= S_STEAL_HEAD;
          end else if (rd_refs == 8'd0) begin
            grant            <= cur;
            fill             <= 1'b1;
            entry_device[ci] <= dev;
            entry_block[ci]  <= blk;
            entry_valid[ci]  <= 1'b1;
            entry_refs[ci]   <= 8'd1;
            state            <= S_FINISH;
          end else begin
            cur   <= rd_link;
            steps <= steps + SW'(1);
          end
        end
        S_STEAL_HEAD: begin
          if (ob == (BW+1)'(BUCKET_COUNT)) begin
            grant  <= '0;
            status <= hbbd_pkg::ST_NO_FREE;
            state  <= S_FINISH;
          end else if (ob[BW-1:0] == bk) begin
            ob <= ob + (BW+1)'(1);
          end else begin
            cur   <= first_rd;
            steps <= '0;
            state <= S_STEAL_WALK;
          end
        end
        S_STEAL_WALK: begin
          if (walk_end) begin
            ob    <= ob + (BW+1)'(1);
            state <= S_STEAL_HEAD;
          end else if (rd_refs == 8'd0) begin
            grant            <= cur;
            victim           <= cur;
            vlink            <= rd_link;
            fill             <= 1'b1;
            entry_device[ci] <= dev;
            entry_block[ci]  <= blk;
            entry_valid[ci]  <= 1'b1;
            entry_refs[ci]   <= 8'd1;
            if (first_rd == cur) begin
              bucket_first[ob[BW-1:0]] <= rd_link;
              state                    <= S_INSERT;
            end else begin
              cur   <= first_rd;
              steps <= '0;
              state <= S_UNLINK;
            end
          end else begin
            cur   <= rd_link;
            steps <= steps + SW'(1);
          end
        end
        S_UNLINK: begin
          if (walk_end) begin
            state <= S_INSERT;
          end else if (rd_link == victim) begin
            entry_link[ci] <= vlink;
            state          <= S_INSERT;
          end else begin
            cur   <= rd_link;
            steps <= steps + SW'(1);
          end
        end
        S_INSERT: begin
          // victim goes to the head of the target bucket
          entry_link[victim[IW-1:0]] <= first_rd;
          bucket_first[bk]           <= victim;
          state                      <= S_FINISH;
        end
        S_OP: begin
          if (cur_ok) begin
            if (op == hbbd_pkg::OP_PIN) begin
              entry_refs[ci] <= refs_inc;
            end else if (rd_refs == 8'd0) begin
              status <= hbbd_pkg::ST_UNDERFLOW;
            end else begin
              entry_refs[ci] <= rd_refs - 8'd1;
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            rsp.buffer_index <= grant[4:0];
            rsp.hit          <= hit;
            rsp.needs_fill   <= fill;
            rsp.status       <= status;
            state            <= S_IDLE;
          end else begin
            rsp_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/hashed_block_buffer_directory_core_test.sv @@
module hashed_block_buffer_directory_core_test;

  localparam int BUFS = 32;
  localparam int BUCKETS = 16;
  localparam int RANDOM_ITEMS = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  hbbd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  hbbd_pkg::rsp_t rsp;

  hashed_block_buffer_directory_core #(.BUFFER_COUNT(BUFS), .BUCKET_COUNT(BUCKETS)) u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // directory copy kept by the testbench
  logic [7:0]  dir_dev [BUFS];
  logic [31:0] dir_blk [BUFS];
  logic        dir_valid [BUFS];
  logic [7:0]  dir_refs [BUFS];
  logic [5:0]  dir_link [BUFS];
  logic [5:0]  dir_head [BUCKETS];

  hbbd_pkg::rsp_t pending_rsp[$];
  int   errors = 0;
  int   reads = 0, hits = 0, steals = 0, no_free = 0, underflows = 0;
  bit   idle_on = 1'b1;

  function automatic void dir_reset();
    for (int b = 0; b < BUCKETS; b++) dir_head[b] = hbbd_pkg::NO_LINK;
    for (int i = 0; i < BUFS; i++) begin
      dir_dev[i] = '0;
      dir_blk[i] = '0;
      dir_valid[i] = 1'b0;
      dir_refs[i] = '0;
      dir_link[i] = dir_head[i % BUCKETS];
      dir_head[i % BUCKETS] = 6'(i);
    end
  endfunction

  // first entry matching the tag, or with no references when want_tag is clear
  function automatic logic [5:0] walk_bucket(int b, bit want_tag, logic [7:0] dv,
                                             logic [31:0] bn);
    logic [5:0] cur;
    cur = dir_head[b];
    for (int s = 0; s < BUFS && cur < BUFS; s++) begin
      if (want_tag ? (dir_dev[cur] == dv && dir_blk[cur] == bn) : (dir_refs[cur] == 0))
        return cur;
      cur = dir_link[cur];
    end
    return hbbd_pkg::NO_LINK;
  endfunction

  function automatic void detach(int b, logic [5:0] v);
    logic [5:0] cur;
    cur = dir_head[b];
    if (cur == v) begin
      dir_head[b] = dir_link[v];
      return;
    end
    for (int s = 0; s < BUFS && cur < BUFS; s++) begin
      if (dir_link[cur] == v) begin
        dir_link[cur] = dir_link[v];
        return;
      end
      cur = dir_link[cur];
    end
  endfunction

  function automatic hbbd_pkg::rsp_t dir_apply(hbbd_pkg::req_t r);
    hbbd_pkg::rsp_t o;
    int home;
    logic [5:0] got;
    bit found;
    o = '0;
    o.status = hbbd_pkg::ST_OK;
    if (r.opcode == hbbd_pkg::OP_READ) begin
      reads++;
      home = r.block_number % BUCKETS;
      found = 1'b0;
      got = walk_bucket(home, 1'b1, r.device_number, r.block_number);
      if (got < BUFS) begin
        if (dir_refs[got] != hbbd_pkg::REFS_MAX) dir_refs[got]++;
        o.hit = 1'b1;
        found = 1'b1;
        hits++;
      end else begin
        got = walk_bucket(home, 1'b0, r.device_number, r.block_number);
        if (got < BUFS) found = 1'b1;
        for (int b = 0; b < BUCKETS && !found; b++) begin
          if (b != home) begin
            got = walk_bucket(b, 1'b0, r.device_number, r.block_number);
            if (got < BUFS) begin
              detach(b, got);
              dir_link[got] = dir_head[home];
              dir_head[home] = got;
              found = 1'b1;
              steals++;
            end
          end
        end
        if (found) begin
          dir_dev[got] = r.device_number;
          dir_blk[got] = r.block_number;
          dir_valid[got] = 1'b0;
          dir_refs[got] = 8'd1;
        end
      end
      if (found) begin
        o.buffer_index = got[4:0];
        o.needs_fill = !dir_valid[got];
        dir_valid[got] = 1'b1;
      end else begin
        o.status = hbbd_pkg::ST_NO_FREE;
        no_free++;
      end
    end else begin
      o.buffer_index = r.buffer_select;
      if (r.buffer_select < BUFS) begin
        if (r.opcode == hbbd_pkg::OP_PIN) begin
          if (dir_refs[r.buffer_select] != hbbd_pkg::REFS_MAX) dir_refs[r.buffer_select]++;
        end else if (dir_refs[r.buffer_select] == 0) begin
          o.status = hbbd_pkg::ST_UNDERFLOW;
          underflows++;
        end else begin
          dir_refs[r.buffer_select]--;
        end
      end
    end
    return o;
  endfunction

  // directed rows: fixed answers where obvious
  typedef struct {
    hbbd_pkg::req_t r;
    bit             fixed;
    hbbd_pkg::rsp_t want;
  } row_t;

  function automatic hbbd_pkg::req_t mk(hbbd_pkg::op_t op, logic [7:0] dv, logic [31:0] bn,
                                        logic [4:0] sel);
    hbbd_pkg::req_t r;
    r.opcode = op;
    r.device_number = dv;
    r.block_number = bn;
    r.buffer_select = sel;
    return r;
  endfunction

  function automatic hbbd_pkg::rsp_t ans(logic [4:0] idx, logic h, logic f,
                                         hbbd_pkg::status_t st);
    hbbd_pkg::rsp_t o;
    o.buffer_index = idx;
    o.hit = h;
    o.needs_fill = f;
    o.status = st;
    return o;
  endfunction

  task automatic send(hbbd_pkg::req_t r, bit fixed, hbbd_pkg::rsp_t want);
    hbbd_pkg::rsp_t p;
    p = dir_apply(r);
    if (fixed && p != want) begin
      $error("directed row disagrees with predictor: %h vs %h", want, p);
      errors++;
    end
    pending_rsp.push_back(p);
    if (idle_on && $urandom_range(99) < 35) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // receiver side
  always @(posedge clk) begin
    if (!rst) rsp_ready <= idle_on ? ($urandom_range(99) >= 35) : 1'b1;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result with nothing expected: %h", rsp);
        errors++;
      end else begin
        hbbd_pkg::rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp.buffer_index !== e.buffer_index) begin
          $error("buffer_index expected %0d actual %0d", e.buffer_index, rsp.buffer_index);
          errors++;
        end
        if (rsp.hit !== e.hit) begin
          $error("hit expected %0d actual %0d", e.hit, rsp.hit);
          errors++;
        end
        if (rsp.needs_fill !== e.needs_fill) begin
          $error("needs_fill expected %0d actual %0d", e.needs_fill, rsp.needs_fill);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp.status);
          errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  row_t rows[$];
  logic [31:0] hot [8];
  logic [7:0]  hot_dev [8];

  initial begin
    hbbd_pkg::req_t r;
    int k;
    dir_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk(hbbd_pkg::OP_READ, 8'h00, 32'h0, 5'd0), 1,
                     ans(5'd16, 1, 1, hbbd_pkg::ST_OK)});
    rows.push_back('{mk(hbbd_pkg::OP_READ, 8'h00, 32'h0, 5'd0), 1,
                     ans(5'd16, 1, 0, hbbd_pkg::ST_OK)});
    rows.push_back('{mk(hbbd_pkg::OP_READ, 8'hff, 32'hffffffff, 5'd31), 1,
                     ans(5'd31, 0, 1, hbbd_pkg::ST_OK)});
    rows.push_back('{mk(hbbd_pkg::OP_REL, 8'h00, 32'h0, 5'd31), 1,
                     ans(5'd31, 0, 0, hbbd_pkg::ST_OK)});
    rows.push_back('{mk(hbbd_pkg::OP_REL, 8'h00, 32'h0, 5'd31), 1,
                     ans(5'd31, 0, 0, hbbd_pkg::ST_UNDERFLOW)});
    rows.push_back('{mk(hbbd_pkg::OP_UNPIN, 8'h00, 32'h0, 5'd5), 1,
                     ans(5'd5, 0, 0, hbbd_pkg::ST_UNDERFLOW)});
    rows.push_back('{mk(hbbd_pkg::OP_PIN, 8'h00, 32'h0, 5'd5), 1,
                     ans(5'd5, 0, 0, hbbd_pkg::ST_OK)});
    rows.push_back('{mk(hbbd_pkg::OP_UNPIN, 8'h00, 32'h0, 5'd5), 1,
                     ans(5'd5, 0, 0, hbbd_pkg::ST_OK)});
    rows.push_back('{mk(hbbd_pkg::OP_READ, 8'h12, 32'h00000010, 5'd0), 0, '0});
    rows.push_back('{mk(hbbd_pkg::OP_READ, 8'h34, 32'h80000020, 5'd0), 0, '0});
    rows.push_back('{mk(hbbd_pkg::OP_READ, 8'h56, 32'h00000030, 5'd0), 0, '0}); // steal from bucket 1
    rows.push_back('{mk(hbbd_pkg::OP_READ, 8'h12, 32'h00000010, 5'd0), 0, '0});
    foreach (rows[i]) send(rows[i].r, rows[i].fixed, rows[i].want);
    drain();

    // pin every buffer to exhaust free ones, saturate one count and unpin it past zero, then release all
    for (int i = 0; i < BUFS; i++) send(mk(hbbd_pkg::OP_PIN, 8'h0, 32'h0, 5'(i)), 0, '0);
    send(mk(hbbd_pkg::OP_READ, 8'h77, 32'h5, 5'd0), 1, ans(5'd0, 0, 0, hbbd_pkg::ST_NO_FREE));
    for (int i = 0; i < 260; i++) send(mk(hbbd_pkg::OP_PIN, 8'h0, 32'h0, 5'd9), 0, '0);
    for (int i = 0; i < 300; i++) send(mk(hbbd_pkg::OP_UNPIN, 8'h0, 32'h0, 5'd9), 0, '0);
    for (int i = 0; i < BUFS; i++) send(mk(hbbd_pkg::OP_REL, 8'h0, 32'h0, 5'(i)), 0, '0);
    drain();

    for (int i = 0; i < 8; i++) begin
      hot[i] = $urandom();
      hot_dev[i] = 8'($urandom());
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 500 && n < 700);
      if (n == 400) drain();
      k = $urandom_range(99);
      r.device_number = 8'($urandom());
      r.block_number = $urandom();
      r.buffer_select = 5'($urandom());
      if (k < 45) begin
        r.opcode = hbbd_pkg::OP_READ;
        if ($urandom_range(1)) begin
          r.block_number = hot[$urandom_range(7)] ^ ($urandom_range(3) << 4);
          r.device_number = hot_dev[r.block_number[2:0]];
        end
      end else if (k < 70) begin
        r.opcode = hbbd_pkg::OP_REL;
      end else if (k < 85) begin
        r.opcode = hbbd_pkg::OP_PIN;
      end else begin
        r.opcode = hbbd_pkg::OP_UNPIN;
      end
      send(r, 0, '0);
    end
    drain();
    idle_on = 1'b0;
    repeat (200) @(posedge clk);

    $display("covered %0d reads: %0d hits, %0d cross-bucket steals, %0d with no free buffer,",
             reads, hits, steals, no_free);
    $display("and %0d count underflows", underflows);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/hbbd_pkg.sv
design/hashed_block_buffer_directory_core.sv
test/hashed_block_buffer_directory_core_test.sv
